### hw/rtl/pfs_pkg.sv
// Shared constants, codes and types for the packet flow statistics block.
package pfs_pkg;

  localparam int ADDR_TABLE_DEPTH = 64;
  localparam int PORT_TABLE_DEPTH = 64;
  localparam int COUNTER_WIDTH    = 64;
  localparam int NUM_COUNTERS     = 14;

  localparam int AAW = $clog2(ADDR_TABLE_DEPTH);
  localparam int AFW = $clog2(ADDR_TABLE_DEPTH + 1);
  localparam int PAW = $clog2(PORT_TABLE_DEPTH);
  localparam int PFW = $clog2(PORT_TABLE_DEPTH + 1);
  localparam int IW  = (AFW > PFW) ? AFW : PFW;
  localparam int CIW = $clog2(NUM_COUNTERS);

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] IP_V4 = 2'd1;
  localparam logic [1:0] IP_V6 = 2'd2;

  localparam logic [1:0] L4_TCP  = 2'd1;
  localparam logic [1:0] L4_UDP  = 2'd2;
  localparam logic [1:0] L4_ICMP = 2'd3;

  localparam logic [1:0] SP_CNT  = 2'd0;
  localparam logic [1:0] SP_ADDR = 2'd1;
  localparam logic [1:0] SP_PORT = 2'd2;

  localparam int CNT_ETH   = 0;
  localparam int CNT_IPV4  = 1;
  localparam int CNT_IPV6  = 2;
  localparam int CNT_TCP   = 3;
  localparam int CNT_TCPB  = 4;
  localparam int CNT_SYN   = 5;
  localparam int CNT_UDP   = 10;
  localparam int CNT_UDPB  = 11;
  localparam int CNT_ICMP  = 12;
  localparam int CNT_TOTAL = 13;

  typedef enum logic [1:0] {
    OP_UPDATE,
    OP_READ,
    OP_CLEAR,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e         op;
    logic        eth;
    logic        ip4;
    logic        ip6;
    logic        tcp;
    logic        udp;
    logic        icmp;
    logic [4:0]  flags;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] len;
    logic [1:0]  space;
    logic [5:0]  idx;
  } pfs_cmd_t;

endpackage

### hw/rtl/pfs_front.sv
// Front end: accepts input beats and classifies them into commands.
module pfs_front (
  input  logic            push,
  output logic            full,
  input  logic [1:0]      cmd_i,
  input  logic            has_eth_i,
  input  logic [1:0]      ip_kind_i,
  input  logic [31:0]     src_ip_i,
  input  logic [31:0]     dst_ip_i,
  input  logic [1:0]      l4_kind_i,
  input  logic [4:0]      tcp_flags_i,
  input  logic [15:0]     src_port_i,
  input  logic [15:0]     dst_port_i,
  input  logic [15:0]     length_i,
  input  logic [1:0]      read_space_i,
  input  logic [5:0]      read_index_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output pfs_pkg::pfs_cmd_t q_item_o
);
  import pfs_pkg::*;

  assign full     = q_full_i;
  assign q_push_o = push & ~q_full_i;

  always_comb begin
    q_item_o = '0;
    case (cmd_i)
      CMD_UPDATE: q_item_o.op = OP_UPDATE;
      CMD_READ:   q_item_o.op = OP_READ;
      CMD_CLEAR:  q_item_o.op = OP_CLEAR;
      default:    q_item_o.op = OP_NONE;
    endcase
    q_item_o.eth      = has_eth_i;
    q_item_o.ip4      = (ip_kind_i == IP_V4);
    q_item_o.ip6      = (ip_kind_i == IP_V6);
    q_item_o.tcp      = (l4_kind_i == L4_TCP);
    q_item_o.udp      = (l4_kind_i == L4_UDP);
    q_item_o.icmp     = (l4_kind_i == L4_ICMP);
    q_item_o.flags    = (l4_kind_i == L4_TCP) ? tcp_flags_i : 5'd0;
    q_item_o.src_ip   = src_ip_i;
    q_item_o.dst_ip   = dst_ip_i;
    q_item_o.src_port = src_port_i;
    q_item_o.dst_port = dst_port_i;
    q_item_o.len      = length_i;
    q_item_o.space    = read_space_i;
    q_item_o.idx      = read_index_i;
  end

endmodule

### hw/rtl/pfs_queue.sv
// Two-entry command queue between front and back end.
module pfs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  pfs_pkg::pfs_cmd_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output pfs_pkg::pfs_cmd_t item_o
);
  import pfs_pkg::*;

  pfs_cmd_t   mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### hw/rtl/pfs_back.sv
// Back end: counters, address and port tables, and the result register.
module pfs_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  pfs_pkg::pfs_cmd_t q_item_i,
  output logic              q_pop_o,
  output logic              busy_o,
  input  logic              pop,
  output logic              empty,
  output logic [63:0]       value_o,
  output logic [63:0]       entry_bytes_o,
  output logic [31:0]       entry_key_o,
  output logic              entry_valid_o,
  output logic [1:0]        status_o
);
  import pfs_pkg::*;

  localparam int CW = COUNTER_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NEXT = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_RDA  = 3'd4;
  localparam logic [2:0] S_RDO  = 3'd5;

  logic [2:0]     state_q, state_d;
  pfs_cmd_t       item_q, item_d;
  logic [3:0]     lk_q, lk_d;
  logic           sel_q, sel_d;
  logic [31:0]    key_q, key_d;
  logic [IW-1:0]  i_q, i_d;
  logic [AFW-1:0] fill_a_q, fill_a_d;
  logic [PFW-1:0] fill_p_q, fill_p_d;
  logic [1:0]     stat_q, stat_d;
  logic [CW-1:0]  cnt_q [NUM_COUNTERS];
  logic [CW-1:0]  cnt_d [NUM_COUNTERS];

  logic           ov_q, ov_d;
  logic [63:0]    val_q, val_d, byt_q, byt_d;
  logic [31:0]    okey_q, okey_d;
  logic           oval_q, oval_d;
  logic [1:0]     ost_q, ost_d;

  logic [31:0]    akey [ADDR_TABLE_DEPTH];
  logic [CW-1:0]  apkt [ADDR_TABLE_DEPTH];
  logic [CW-1:0]  abyt [ADDR_TABLE_DEPTH];
  logic [15:0]    pkey [PORT_TABLE_DEPTH];
  logic [CW-1:0]  ppkt [PORT_TABLE_DEPTH];
  logic [CW-1:0]  pbyt [PORT_TABLE_DEPTH];

  logic [31:0]    akey_rd;
  logic [CW-1:0]  apkt_rd, abyt_rd;
  logic [15:0]    pkey_rd;
  logic [CW-1:0]  ppkt_rd, pbyt_rd;

  logic           a_we, p_we;
  logic [AAW-1:0] a_wa, a_ra;
  logic [PAW-1:0] p_wa, p_ra;
  logic [CW-1:0]  w_pkt, w_byt;

  logic [CW-1:0]  q_len, i_len;
  logic [IW+5:0]  idx_w, fa_w, fp_w;
  logic           hit;

  assign q_len  = CW'(q_item_i.len);
  assign i_len  = CW'(item_q.len);
  assign idx_w  = (IW + 6)'(item_q.idx);
  assign fa_w   = (IW + 6)'(fill_a_q);
  assign fp_w   = (IW + 6)'(fill_p_q);
  assign hit    = sel_q ? ({16'd0, pkey_rd} == key_q) : (akey_rd == key_q);
  assign busy_o = (state_q != S_IDLE);
  assign empty  = ~ov_q;

  assign value_o       = val_q;
  assign entry_bytes_o = byt_q;
  assign entry_key_o   = okey_q;
  assign entry_valid_o = oval_q;
  assign status_o      = ost_q;

  always_comb begin
    state_d  = state_q;
    item_d   = item_q;
    lk_d     = lk_q;
    sel_d    = sel_q;
    key_d    = key_q;
    i_d      = i_q;
    fill_a_d = fill_a_q;
    fill_p_d = fill_p_q;
    stat_d   = stat_q;
    cnt_d    = cnt_q;
    q_pop_o  = 1'b0;
    ov_d     = ov_q & ~pop;
    val_d    = val_q;
    byt_d    = byt_q;
    okey_d   = okey_q;
    oval_d   = oval_q;
    ost_d    = ost_q;
    a_we     = 1'b0;
    p_we     = 1'b0;
    a_wa     = i_q[AAW-1:0];
    p_wa     = i_q[PAW-1:0];
    a_ra     = idx_w[AAW-1:0];
    p_ra     = idx_w[PAW-1:0];
    w_pkt    = CW'(1);
    w_byt    = i_len;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !ov_q) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          case (q_item_i.op)
            OP_UPDATE: begin
              if (q_item_i.eth) cnt_d[CNT_ETH] = cnt_q[CNT_ETH] + CW'(1);
              if (q_item_i.ip4) cnt_d[CNT_IPV4] = cnt_q[CNT_IPV4] + CW'(1);
              if (q_item_i.ip6) cnt_d[CNT_IPV6] = cnt_q[CNT_IPV6] + CW'(1);
              if (q_item_i.tcp) begin
                cnt_d[CNT_TCP]  = cnt_q[CNT_TCP] + CW'(1);
                cnt_d[CNT_TCPB] = cnt_q[CNT_TCPB] + q_len;
              end
              for (int b = 0; b < 5; b++) begin
                if (q_item_i.flags[b]) cnt_d[CNT_SYN + b] = cnt_q[CNT_SYN + b] + CW'(1);
              end
              if (q_item_i.udp) begin
                cnt_d[CNT_UDP]  = cnt_q[CNT_UDP] + CW'(1);
                cnt_d[CNT_UDPB] = cnt_q[CNT_UDPB] + q_len;
              end
              if (q_item_i.icmp) cnt_d[CNT_ICMP] = cnt_q[CNT_ICMP] + CW'(1);
              cnt_d[CNT_TOTAL] = cnt_q[CNT_TOTAL] + q_len;
              lk_d   = {{2{q_item_i.tcp | q_item_i.udp}}, {2{q_item_i.ip4}}};
              stat_d = 2'd0;
              state_d = S_NEXT;
            end
            OP_READ: begin
              if (q_item_i.space == SP_CNT) begin
                ov_d   = 1'b1;
                byt_d  = '0;
                okey_d = '0;
                ost_d  = '0;
                if (q_item_i.idx < 6'(NUM_COUNTERS)) begin
                  val_d  = 64'(cnt_q[q_item_i.idx[CIW-1:0]]);
                  oval_d = 1'b1;
                end else begin
                  val_d  = '0;
                  oval_d = 1'b0;
                end
              end else begin
                state_d = S_RDA;
              end
            end
            OP_CLEAR: begin
              for (int k = 0; k < NUM_COUNTERS; k++) cnt_d[k] = '0;
              fill_a_d = '0;
              fill_p_d = '0;
              ov_d   = 1'b1;
              val_d  = '0;
              byt_d  = '0;
              okey_d = '0;
              oval_d = 1'b0;
              ost_d  = '0;
            end
            default: begin
              ov_d   = 1'b1;
              val_d  = '0;
              byt_d  = '0;
              okey_d = '0;
              oval_d = 1'b0;
              ost_d  = '0;
            end
          endcase
        end
      end
      S_NEXT: begin
        i_d = '0;
        if (lk_q == 4'd0) begin
          ov_d    = 1'b1;
          val_d   = '0;
          byt_d   = '0;
          okey_d  = '0;
          oval_d  = 1'b0;
          ost_d   = stat_q;
          state_d = S_IDLE;
        end else begin
          state_d = S_RD;
          if (lk_q[0]) begin
            lk_d[0] = 1'b0;
            sel_d   = 1'b0;
            key_d   = item_q.src_ip;
          end else if (lk_q[1]) begin
            lk_d[1] = 1'b0;
            sel_d   = 1'b0;
            key_d   = item_q.dst_ip;
          end else if (lk_q[2]) begin
            lk_d[2] = 1'b0;
            sel_d   = 1'b1;
            key_d   = {16'd0, item_q.src_port};
          end else begin
            lk_d[3] = 1'b0;
            sel_d   = 1'b1;
            key_d   = {16'd0, item_q.dst_port};
          end
        end
      end
      S_RD: begin
        a_ra = i_q[AAW-1:0];
        p_ra = i_q[PAW-1:0];
        if (!sel_q) begin
          if (i_q >= IW'(fill_a_q)) begin
            state_d = S_NEXT;
            if (fill_a_q == AFW'(ADDR_TABLE_DEPTH)) begin
              stat_d[0] = 1'b1;
            end else begin
              a_we     = 1'b1;
              a_wa     = fill_a_q[AAW-1:0];
              fill_a_d = fill_a_q + AFW'(1);
            end
          end else begin
            state_d = S_CMP;
          end
        end else begin
          if (i_q >= IW'(fill_p_q)) begin
            state_d = S_NEXT;
            if (fill_p_q == PFW'(PORT_TABLE_DEPTH)) begin
              stat_d[1] = 1'b1;
            end else begin
              p_we     = 1'b1;
              p_wa     = fill_p_q[PAW-1:0];
              fill_p_d = fill_p_q + PFW'(1);
            end
          end else begin
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (hit) begin
          a_we    = ~sel_q;
          p_we    = sel_q;
          w_pkt   = (sel_q ? ppkt_rd : apkt_rd) + CW'(1);
          w_byt   = (sel_q ? pbyt_rd : abyt_rd) + i_len;
          state_d = S_NEXT;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = S_RD;
        end
      end
      S_RDA: begin
        state_d = S_RDO;
      end
      S_RDO: begin
        ov_d    = 1'b1;
        ost_d   = '0;
        state_d = S_IDLE;
        if (item_q.space == SP_ADDR && idx_w < fa_w) begin
          val_d  = 64'(apkt_rd);
          byt_d  = 64'(abyt_rd);
          okey_d = akey_rd;
          oval_d = 1'b1;
        end else if (item_q.space == SP_PORT && idx_w < fp_w) begin
          val_d  = 64'(ppkt_rd);
          byt_d  = 64'(pbyt_rd);
          okey_d = {16'd0, pkey_rd};
          oval_d = 1'b1;
        end else begin
          val_d  = '0;
          byt_d  = '0;
          okey_d = '0;
          oval_d = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lk_q     <= '0;
      sel_q    <= 1'b0;
      i_q      <= '0;
      fill_a_q <= '0;
      fill_p_q <= '0;
      stat_q   <= '0;
      ov_q     <= 1'b0;
      for (int k = 0; k < NUM_COUNTERS; k++) cnt_q[k] <= '0;
    end else begin
      state_q  <= state_d;
      lk_q     <= lk_d;
      sel_q    <= sel_d;
      i_q      <= i_d;
      fill_a_q <= fill_a_d;
      fill_p_q <= fill_p_d;
      stat_q   <= stat_d;
      ov_q     <= ov_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    key_q  <= key_d;
    val_q  <= val_d;
    byt_q  <= byt_d;
    okey_q <= okey_d;
    oval_q <= oval_d;
    ost_q  <= ost_d;
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      akey[a_wa] <= key_q;
      apkt[a_wa] <= w_pkt;
      abyt[a_wa] <= w_byt;
    end
    akey_rd <= akey[a_ra];
    apkt_rd <= apkt[a_ra];
    abyt_rd <= abyt[a_ra];
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pkey[p_wa] <= key_q[15:0];
      ppkt[p_wa] <= w_pkt;
      pbyt[p_wa] <= w_byt;
    end
    pkey_rd <= pkey[p_ra];
    ppkt_rd <= ppkt[p_ra];
    pbyt_rd <= pbyt[p_ra];
  end

endmodule

### hw/rtl/packet_flow_statistics.sv
// Packet flow statistics: protocol counters plus address and port tables.
//
// Input channel: push/full. One beat carries a packet update, a read or a
// clear. Result channel: empty/pop. Every input beat yields exactly one
// result beat, in order; the result shows while empty is low.
// A two-entry command queue parts the front end from the back end, so the
// input keeps taking beats while a result waits to be popped.
// Work per item in the back end:
//   read of a counter, clear, unused command: done when taken from the queue
//   read of a table entry: a table read state, then the result state
//   packet update: counters update when taken, then up to four lookups
//   (source and destination address, source and destination port), each
//   scanning the filled entries and inserting a new entry on a miss; the
//   scan reads one table entry at a time through the registered table
//   memory port, then compares it.
// A full table drops the insert and flags it in status.
// Reset clears all counters and both fill counts; the command queue and the result register come up empty.
// When the receiver stalls, the result holds and the back end waits before
// starting the next item; the input side stalls once the queue fills.
module packet_flow_statistics (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd_i,
  input  logic        has_eth_i,
  input  logic [1:0]  ip_kind_i,
  input  logic [31:0] src_ip_i,
  input  logic [31:0] dst_ip_i,
  input  logic [1:0]  l4_kind_i,
  input  logic [4:0]  tcp_flags_i,
  input  logic [15:0] src_port_i,
  input  logic [15:0] dst_port_i,
  input  logic [15:0] length_i,
  input  logic [1:0]  read_space_i,
  input  logic [5:0]  read_index_i,
  input  logic        pop,
  output logic        empty,
  output logic [63:0] value_o,
  output logic [63:0] entry_bytes_o,
  output logic [31:0] entry_key_o,
  output logic        entry_valid_o,
  output logic [1:0]  status_o
);
  import pfs_pkg::*;

  logic     q_full, q_push, q_pop, q_valid, busy;
  pfs_cmd_t q_in, q_out;

  pfs_front u_front (
    .push         (push),
    .full         (full),
    .cmd_i        (cmd_i),
    .has_eth_i    (has_eth_i),
    .ip_kind_i    (ip_kind_i),
    .src_ip_i     (src_ip_i),
    .dst_ip_i     (dst_ip_i),
    .l4_kind_i    (l4_kind_i),
    .tcp_flags_i  (tcp_flags_i),
    .src_port_i   (src_port_i),
    .dst_port_i   (dst_port_i),
    .length_i     (length_i),
    .read_space_i (read_space_i),
    .read_index_i (read_index_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_item_o     (q_in)
  );

  pfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  pfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .busy_o        (busy),
    .pop           (pop),
    .empty         (empty),
    .value_o       (value_o),
    .entry_bytes_o (entry_bytes_o),
    .entry_key_o   (entry_key_o),
    .entry_valid_o (entry_valid_o),
    .status_o      (status_o)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("command queue popped while empty");

  a_pop_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (busy || !empty)) else $error("popped command neither running nor done");

  a_busy_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> empty) else $error("back end running while a result is pending");

endmodule
